### rtl/fcw_pkg.sv
// shared types and constants for the framed crc22 word checker
package fcw_pkg;

  localparam int WordWidth  = 16;
  localparam int CrcWidth   = 22;
  localparam int HalfWidth  = 11;
  localparam int LenWidth   = 12;
  localparam int CountWidth = 2;

  localparam logic [WordWidth-1:0] StartMarkA = 16'h6B0C;
  localparam logic [WordWidth-1:0] StartMarkB = 16'hDB0C;
  localparam logic [WordWidth-1:0] EndMark    = 16'hDE0F;

  localparam logic [LenWidth-1:0]   MaxFrameReset = 12'd4095;
  localparam logic [CountWidth-1:0] HeldNone      = 2'd0;
  localparam logic [CountWidth-1:0] HeldOne       = 2'd1;
  localparam logic [CountWidth-1:0] HeldTwo       = 2'd2;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_OVERLONG = 2'd2
  } status_t;

  typedef struct packed {
    logic [CrcWidth-1:0] computed;
    logic [CrcWidth-1:0] received;
    logic                match;
    status_t             status;
  } result_t;

endpackage

### rtl/fcw_crc22.sv
// 16-bit-parallel crc22 update, one word per call
module fcw_crc22
  import fcw_pkg::*;
(
  input  logic [WordWidth-1:0] word,
  input  logic [CrcWidth-1:0]  crc,
  output logic [CrcWidth-1:0]  crc_next
);

  always_comb begin
    crc_next[0]     = word[0] ^ crc[6];
    crc_next[15:1]  = word[15:1] ^ word[14:0] ^ crc[20:6] ^ crc[21:7];
    crc_next[16]    = word[15] ^ crc[0] ^ crc[21];
    crc_next[21:17] = crc[5:1];
  end

endmodule

### rtl/fcw_frame_tracker.sv
// frame state, two-word delay line, crc accumulator and result forming
module fcw_frame_tracker
  import fcw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [WordWidth-1:0] word,
  input  logic [LenWidth-1:0] max_frame_words,
  output logic                result_valid,
  output result_t             result
);

  logic                  in_frame, in_frame_next;
  logic [CrcWidth-1:0]   crc_acc, crc_acc_next;
  logic [WordWidth-1:0]  held0, held0_next;
  logic [WordWidth-1:0]  held1, held1_next;
  logic [CountWidth-1:0] held_count, held_count_next;
  logic [LenWidth-1:0]   frame_length, frame_length_next;
  logic [CrcWidth-1:0]   crc_folded;
  logic [CrcWidth-1:0]   received;
  logic                  is_start;

  fcw_crc22 u_crc (
    .word     (held0),
    .crc      (crc_acc),
    .crc_next (crc_folded)
  );

  assign is_start = (word == StartMarkA) || (word == StartMarkB);
  // newer word gives the high half, older word the low half
  assign received = {held1[HalfWidth-1:0], held0[HalfWidth-1:0]};

  always_comb begin
    in_frame_next     = in_frame;
    crc_acc_next      = crc_acc;
    held0_next        = held0;
    held1_next        = held1;
    held_count_next   = held_count;
    frame_length_next = frame_length;
    result_valid      = 1'b0;
    result.computed   = crc_acc;
    result.received   = '0;
    result.match      = 1'b0;
    result.status     = STATUS_OK;
    if (step) begin
      if (!in_frame) begin
        if (is_start) begin
          in_frame_next     = 1'b1;
          crc_acc_next      = '0;
          held0_next        = word;
          held_count_next   = HeldOne;
          frame_length_next = LenWidth'(1);
        end
      end else if (frame_length >= max_frame_words || word == EndMark) begin
        result_valid = 1'b1;
        if (frame_length >= max_frame_words) begin
          result.status = STATUS_OVERLONG;
        end else if (held_count != HeldTwo) begin
          result.status = STATUS_SHORT;
        end else begin
          result.received = received;
          result.match    = (crc_acc == received);
        end
        in_frame_next     = 1'b0;
        crc_acc_next      = '0;
        held_count_next   = HeldNone;
        frame_length_next = '0;
      end else begin
        // push into the delay line; once it is full, the oldest word falls into the crc
        if (held_count == HeldTwo) begin
          crc_acc_next = crc_folded;
          held0_next   = held1;
          held1_next   = word;
        end else if (held_count == HeldOne) begin
          held1_next      = word;
          held_count_next = HeldTwo;
        end else begin
          held0_next      = word;
          held_count_next = HeldOne;
        end
        frame_length_next = frame_length + LenWidth'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      crc_acc      <= '0;
      held_count   <= HeldNone;
      frame_length <= '0;
    end else begin
      in_frame     <= in_frame_next;
      crc_acc      <= crc_acc_next;
      held_count   <= held_count_next;
      frame_length <= frame_length_next;
    end
  end

  always_ff @(posedge clk) begin
    held0 <= held0_next;
    held1 <= held1_next;
  end

`ifndef SYNTHESIS
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (held_count == HeldNone && frame_length == '0 && crc_acc == '0))
    else $error("idle with leftover frame state");

  a_frame_holds_word: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (held_count == HeldOne || held_count == HeldTwo))
    else $error("open frame with empty delay line");

  a_match_only_ok: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.match) |-> (result.status == STATUS_OK))
    else $error("match flagged on a bad frame");

  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    (step && !in_frame && is_start) |=> (in_frame && frame_length == LenWidth'(1)))
    else $error("start marker did not open a frame");

  a_result_closes: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !in_frame)
    else $error("frame still open after result");
`endif

endmodule

### rtl/framed_crc22_word_checker.sv
// Framed CRC22 word checker. One 16-bit word is taken per cycle while in_stall
// is low; a word lands in an input register, is processed against the frame
// state once no result is stuck at the output, and its result (end marker or
// overlong abort) is registered in the output register. The combinational
// crc22 fold in the frame tracker sets the pace. Input stall rises only when the
// input register holds a word and the output register holds a result that the
// receiver stalls. The user writes max_frame_words through the cfg channel only
// while idle; the block itself does not enforce this. cfg_ready is always high.
module framed_crc22_word_checker
  import fcw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LenWidth-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WordWidth-1:0] data_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CrcWidth-1:0]  computed_crc,
  output logic [CrcWidth-1:0]  received_crc,
  output logic                 crc_match,
  output logic [1:0]           frame_status
);

  logic [LenWidth-1:0]  max_frame_words;
  logic                 in_reg_valid;
  logic [WordWidth-1:0] in_reg_word;
  logic                 advance;
  logic                 result_valid;
  result_t              result;
  result_t              out_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_words <= MaxFrameReset;
    end else if (cfg_valid && cfg_ready) begin
      max_frame_words <= cfg_data;
    end
  end

  // processing may go ahead unless a result beat is stuck at the output
  assign advance  = in_reg_valid && !(out_valid && out_stall);
  assign in_stall = in_reg_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_word <= data_word;
    end
  end

  fcw_frame_tracker u_tracker (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .word            (in_reg_word),
    .max_frame_words (max_frame_words),
    .result_valid    (result_valid),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!(out_valid && out_stall)) begin
      out_valid <= result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid && !(out_valid && out_stall)) begin
      out_result <= result;
    end
  end

  assign computed_crc = out_result.computed;
  assign received_crc = out_result.received;
  assign crc_match    = out_result.match;
  assign frame_status = out_result.status;

endmodule
